[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the pid speed controller
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    localparam int SPEED_BITS = 16;
    localparam int SUM_BITS   = 32;
    localparam int TGT_BITS   = 13;
    localparam int DIV_BITS   = 16;
    localparam int ERR_BITS   = 17;
    localparam int DIFF_BITS  = 18;
    localparam int TRIAL_BITS = 34;
    localparam int CNT_BITS   = 5;
    localparam int IDX_BITS   = 4;

    localparam logic signed [TGT_BITS-1:0] TARGET_MAX = 13'sd3000;
    localparam logic signed [TGT_BITS-1:0] TARGET_MIN = -13'sd3000;
    localparam logic signed [TRIAL_BITS-1:0] DRIVE_MAX = 34'sd100;
    localparam logic signed [TRIAL_BITS-1:0] DRIVE_MIN = -34'sd100;
    localparam logic signed [SUM_BITS:0] SUM_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [SUM_BITS:0] SUM_MIN = -33'sh0_8000_0000;

    localparam logic [DIV_BITS-1:0] KP_RESET = 16'd20;
    localparam logic [DIV_BITS-1:0] KI_RESET = 16'd1000;
    localparam logic [DIV_BITS-1:0] KD_RESET = 16'd10;

    localparam logic [IDX_BITS-1:0] REG_TARGET = 4'd0;
    localparam logic [IDX_BITS-1:0] REG_KP     = 4'd1;
    localparam logic [IDX_BITS-1:0] REG_KI     = 4'd2;
    localparam logic [IDX_BITS-1:0] REG_KD     = 4'd3;

    typedef struct packed {
        logic signed [TGT_BITS-1:0] target;
        logic [DIV_BITS-1:0]        kp;
        logic [DIV_BITS-1:0]        ki;
        logic [DIV_BITS-1:0]        kd;
    } psc_cfg_t;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] numer;
        logic [DIV_BITS-1:0]        divisor;
    } psc_div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SUM_BITS-1:0] quot;
    } psc_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_ISSUE,
        ST_WAIT,
        ST_SUM,
        ST_DECIDE,
        ST_OUT
    } psc_state_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_PI,
        TERM_D,
        TERM_I
    } psc_term_t;

endpackage

`default_nettype wire

[hdl/pid_speed_controller.sv]
// ----------------------------------------------------------------------------
// pid_speed_controller
// pid speed loop with conditional integration, one shared serial divider
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one measured speed per request; each request yields one
//   result on m_tdata: the clamped drive command and the speed error.
//   the cfg channel writes the setpoint and the three divisors; cfg_ready is
//   always high and writes take effect on the next cycle.
//   an item goes from input accept to m_tvalid in these steps: the error is
//   formed, then four divisions (p, proposed i, d, held i) run on the
//   bit-serial divider, then the sum is formed, the anti-windup condition
//   is tested and the drive clamped, and the output register is loaded.
//   each division runs through the divider's 32 steps.
//   one item is processed at a time; s_tready is high only while idle, so
//   a new request is accepted only after the last result has been loaded.
//   if the receiver stalls, the finished result waits in the output register
//   and the next item may already be accepted and worked on; it is held in
//   the pipeline until the output register is free.
//   reset clears the integral and the last error, sets the first-update flag,
//   and loads setpoint 0 and divisors 20, 1000 and 10.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_speed_controller (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // measured_speed [15:0]
    input  wire logic [15:0]                   s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // drive_command [7:0], speed_error [24:8], zero [31:25]
    output logic [31:0]                        m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [psc_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [psc_pkg::DIV_BITS-1:0]  cfg_data
);

    psc_pkg::psc_cfg_t      cfg;
    psc_pkg::psc_div_req_t  div_req;
    psc_pkg::psc_div_rsp_t  div_rsp;

    psc_pkg::psc_state_t    state_reg;
    psc_pkg::psc_state_t    state_next;
    psc_pkg::psc_term_t     term_reg;
    psc_pkg::psc_term_t     term_next;

    logic signed [psc_pkg::SPEED_BITS-1:0]  speed_reg;
    logic signed [psc_pkg::ERR_BITS-1:0]    err_reg;
    logic signed [psc_pkg::ERR_BITS-1:0]    last_err_reg;
    logic signed [psc_pkg::DIFF_BITS-1:0]   diff_reg;
    logic signed [psc_pkg::SUM_BITS-1:0]    sum_reg;
    logic signed [psc_pkg::SUM_BITS-1:0]    prop_reg;
    logic                                   first_reg;
    logic signed [psc_pkg::ERR_BITS-1:0]    p_reg;
    logic signed [psc_pkg::SUM_BITS-1:0]    pi_reg;
    logic signed [psc_pkg::DIFF_BITS-1:0]   d_reg;
    logic signed [psc_pkg::SUM_BITS-1:0]    i_reg;
    logic signed [psc_pkg::DIFF_BITS:0]     pd_reg;
    logic signed [7:0]                      drive_reg;
    logic signed [psc_pkg::ERR_BITS-1:0]    out_err_reg;
    logic signed [7:0]                      out_drive_reg;
    logic                                   m_valid_reg;

    logic signed [psc_pkg::DIFF_BITS-1:0]   err_wide;
    logic signed [psc_pkg::SUM_BITS:0]      sum_wide;
    logic signed [psc_pkg::SUM_BITS-1:0]    prop_sat;
    logic signed [psc_pkg::TRIAL_BITS-1:0]  trial;
    logic signed [psc_pkg::TRIAL_BITS-1:0]  held;
    logic signed [psc_pkg::TRIAL_BITS-1:0]  total;
    logic                                   err_pos;
    logic                                   err_neg;
    logic                                   refuse;
    logic                                   out_free;

    psc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == psc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_drive_reg};
    assign out_free = !m_valid_reg || m_tready;

    // error and proposed integral
    assign err_wide = 18'(cfg.target) - 18'(speed_reg);
    assign sum_wide = 33'(sum_reg) + 33'(err_reg);
    always_comb begin
        if (sum_wide > psc_pkg::SUM_MAX) begin
            prop_sat = psc_pkg::SUM_MAX[psc_pkg::SUM_BITS-1:0];
        end else if (sum_wide < psc_pkg::SUM_MIN) begin
            prop_sat = psc_pkg::SUM_MIN[psc_pkg::SUM_BITS-1:0];
        end else begin
            prop_sat = sum_wide[psc_pkg::SUM_BITS-1:0];
        end
    end

    // anti-windup test and clamp
    assign trial   = 34'(pd_reg) + 34'(pi_reg);
    assign held    = 34'(pd_reg) + 34'(i_reg);
    assign err_pos = !err_reg[psc_pkg::ERR_BITS-1] && (err_reg != '0);
    assign err_neg = err_reg[psc_pkg::ERR_BITS-1];
    assign refuse  = ((trial > psc_pkg::DRIVE_MAX) && err_pos)
                  || ((trial < psc_pkg::DRIVE_MIN) && err_neg);
    assign total   = refuse ? held : trial;

    // divider operand selection
    always_comb begin
        div_req.start = (state_reg == psc_pkg::ST_ISSUE);
        case (term_reg)
            psc_pkg::TERM_P: begin
                div_req.numer   = 32'(err_reg);
                div_req.divisor = cfg.kp;
            end
            psc_pkg::TERM_PI: begin
                div_req.numer   = prop_reg;
                div_req.divisor = cfg.ki;
            end
            psc_pkg::TERM_D: begin
                div_req.numer   = 32'(diff_reg);
                div_req.divisor = cfg.kd;
            end
            psc_pkg::TERM_I: begin
                div_req.numer   = sum_reg;
                div_req.divisor = cfg.ki;
            end
            default: begin
                div_req.numer   = '0;
                div_req.divisor = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            psc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = psc_pkg::ST_ERR;
                end
            end
            psc_pkg::ST_ERR: begin
                term_next  = psc_pkg::TERM_P;
                state_next = psc_pkg::ST_ISSUE;
            end
            psc_pkg::ST_ISSUE: begin
                state_next = psc_pkg::ST_WAIT;
            end
            psc_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    if (term_reg == psc_pkg::TERM_I) begin
                        state_next = psc_pkg::ST_SUM;
                    end else begin
                        term_next  = psc_pkg::psc_term_t'(term_reg + 2'd1);
                        state_next = psc_pkg::ST_ISSUE;
                    end
                end
            end
            psc_pkg::ST_SUM: begin
                state_next = psc_pkg::ST_DECIDE;
            end
            psc_pkg::ST_DECIDE: begin
                state_next = psc_pkg::ST_OUT;
            end
            psc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = psc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psc_pkg::ST_IDLE;
            term_reg     <= psc_pkg::TERM_P;
            sum_reg      <= '0;
            last_err_reg <= '0;
            first_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            if (state_reg == psc_pkg::ST_DECIDE) begin
                if (!refuse) begin
                    sum_reg <= prop_reg;
                end
                last_err_reg <= err_reg;
                first_reg    <= 1'b0;
            end
            if (state_reg == psc_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            speed_reg <= signed'(s_tdata);
        end
        if (state_reg == psc_pkg::ST_ERR) begin
            err_reg <= err_wide[psc_pkg::ERR_BITS-1:0];
        end
        if (state_reg == psc_pkg::ST_ISSUE && term_reg == psc_pkg::TERM_P) begin
            prop_reg <= prop_sat;
            diff_reg <= 18'(err_reg) - 18'(last_err_reg);
        end
        if (state_reg == psc_pkg::ST_WAIT && div_rsp.done) begin
            case (term_reg)
                psc_pkg::TERM_P:  p_reg  <= div_rsp.quot[psc_pkg::ERR_BITS-1:0];
                psc_pkg::TERM_PI: pi_reg <= div_rsp.quot;
                psc_pkg::TERM_D:  d_reg  <= div_rsp.quot[psc_pkg::DIFF_BITS-1:0];
                psc_pkg::TERM_I:  i_reg  <= div_rsp.quot;
                default:          p_reg  <= p_reg;
            endcase
        end
        if (state_reg == psc_pkg::ST_SUM) begin
            pd_reg <= 19'(p_reg) + (first_reg ? 19'sd0 : 19'(d_reg));
        end
        if (state_reg == psc_pkg::ST_DECIDE) begin
            if (total > psc_pkg::DRIVE_MAX) begin
                drive_reg <= psc_pkg::DRIVE_MAX[7:0];
            end else if (total < psc_pkg::DRIVE_MIN) begin
                drive_reg <= psc_pkg::DRIVE_MIN[7:0];
            end else begin
                drive_reg <= total[7:0];
            end
        end
        if (state_reg == psc_pkg::ST_OUT && out_free) begin
            out_drive_reg <= drive_reg;
            out_err_reg   <= err_reg;
        end
    end

endmodule

`default_nettype wire

[hdl/psc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// psc_cfg_regs
// setpoint and divisor registers, setpoint clamped on write
// ----------------------------------------------------------------------------
`default_nettype none

module psc_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [psc_pkg::IDX_BITS-1:0]    cfg_index,
    input  wire logic [psc_pkg::DIV_BITS-1:0]    cfg_data,
    output psc_pkg::psc_cfg_t                    cfg
);

    psc_pkg::psc_cfg_t                     cfg_reg;
    psc_pkg::psc_cfg_t                     cfg_next;
    logic signed [psc_pkg::TGT_BITS-1:0]   tgt_raw;
    logic signed [psc_pkg::TGT_BITS-1:0]   tgt_clamped;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign tgt_raw   = signed'(cfg_data[psc_pkg::TGT_BITS-1:0]);

    always_comb begin
        if (tgt_raw > psc_pkg::TARGET_MAX) begin
            tgt_clamped = psc_pkg::TARGET_MAX;
        end else if (tgt_raw < psc_pkg::TARGET_MIN) begin
            tgt_clamped = psc_pkg::TARGET_MIN;
        end else begin
            tgt_clamped = tgt_raw;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                psc_pkg::REG_TARGET: cfg_next.target = tgt_clamped;
                psc_pkg::REG_KP:     cfg_next.kp     = cfg_data;
                psc_pkg::REG_KI:     cfg_next.ki     = cfg_data;
                psc_pkg::REG_KD:     cfg_next.kd     = cfg_data;
                default:             cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= '0;
            cfg_reg.kp     <= psc_pkg::KP_RESET;
            cfg_reg.ki     <= psc_pkg::KI_RESET;
            cfg_reg.kd     <= psc_pkg::KD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hdl/psc_serial_div.sv]
// ----------------------------------------------------------------------------
// psc_serial_div
// bit-serial restoring divider, signed numerator, unsigned divisor,
// quotient truncated toward zero, zero divisor gives zero
// ----------------------------------------------------------------------------
`default_nettype none

module psc_serial_div (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire psc_pkg::psc_div_req_t  req,
    output psc_pkg::psc_div_rsp_t       rsp
);

    logic [psc_pkg::SUM_BITS-1:0]  acc_reg;
    logic [psc_pkg::SUM_BITS-1:0]  acc_next;
    logic [psc_pkg::DIV_BITS-1:0]  rem_reg;
    logic [psc_pkg::DIV_BITS-1:0]  rem_next;
    logic [psc_pkg::DIV_BITS-1:0]  dvs_reg;
    logic [psc_pkg::CNT_BITS-1:0]  cnt_reg;
    logic                          neg_reg;
    logic                          zero_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [psc_pkg::DIV_BITS:0]    shifted;
    logic [psc_pkg::DIV_BITS+1:0]  trial;
    logic                          fits;
    logic [psc_pkg::SUM_BITS-1:0]  start_mag;

    assign start_mag = req.numer[psc_pkg::SUM_BITS-1] ? (~req.numer + 1'b1)
                                                      : req.numer;

    // one quotient bit per cycle
    assign shifted = {rem_reg, acc_reg[psc_pkg::SUM_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[psc_pkg::DIV_BITS+1];
    assign rem_next = fits ? trial[psc_pkg::DIV_BITS-1:0] : shifted[psc_pkg::DIV_BITS-1:0];
    assign acc_next = {acc_reg[psc_pkg::SUM_BITS-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg  <= start_mag;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
            neg_reg  <= req.numer[psc_pkg::SUM_BITS-1];
            zero_reg <= (req.divisor == '0);
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    always_comb begin
        rsp.done = done_reg;
        if (zero_reg) begin
            rsp.quot = '0;
        end else if (neg_reg) begin
            rsp.quot = signed'(~acc_reg + 1'b1);
        end else begin
            rsp.quot = signed'(acc_reg);
        end
    end

endmodule

`default_nettype wire
